FILE: design/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants for the cubic B-spline basis evaluator
// Grid constants, boundary weight table, fixed-point constants and the
// structs passed between the evaluator's modules.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // Node index space; node and last-node indices wrap on this power of two
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  // Signed spline center: node -1 up to node MAX_NODES
  localparam int unsigned CTR_W     = NODE_W + 2;

  // Pipeline depth of one spline evaluation, in register stages
  localparam int unsigned SPL_LAT = 7;

  // Q16.16 one and two on the 18-bit offset path
  localparam logic [17:0] Q_ONE = 18'h1_0000;
  localparam logic [17:0] Q_TWO = 18'h2_0000;

  // Value rounding: half of 6 in units of 2^32, added after the shift
  localparam logic [20:0] VAL_RND = 21'd3;
  // floor(x / 3) = (x * RECIP3_MUL) >> 21, exact for x < 2^21
  localparam logic [19:0] RECIP3_MUL = 20'd699051;
  // Derivative rounding: half of 2^33
  localparam logic [64:0] DER_RND = 65'h0_0000_0001_0000_0000;

  // Largest basis value (2/3 in Q16.16, rounded)
  localparam logic signed [31:0] VALUE_MAX = 32'sd43691;

  localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;

  // Boundary condition rows and node-place columns
  localparam logic [3:0] BC_ROW_MAX = 4'd8;
  localparam logic [1:0] COL_LAST_M1 = 2'd2;
  localparam logic [1:0] COL_LAST    = 2'd3;

  localparam logic signed [3:0] BC_WEIGHT [0:8][0:3] = '{
    '{-4'sd4, -4'sd1, -4'sd1, -4'sd4},
    '{ 4'sd0,  4'sd1,  4'sd1,  4'sd0},
    '{ 4'sd2, -4'sd1, -4'sd1,  4'sd2},
    '{-4'sd4, -4'sd1,  4'sd1,  4'sd0},
    '{-4'sd4, -4'sd1, -4'sd1,  4'sd2},
    '{ 4'sd0,  4'sd1, -4'sd1, -4'sd4},
    '{ 4'sd0,  4'sd1, -4'sd1,  4'sd2},
    '{ 4'sd2, -4'sd1, -4'sd1, -4'sd4},
    '{ 4'sd2, -4'sd1,  4'sd1,  4'sd0}
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GRID_MIN  = 2'd0,
    REG_SPACING   = 2'd1,
    REG_RECIP     = 2'd2,
    REG_LAST_NODE = 2'd3
  } cfg_reg_t;

  // Grid settings seen by each spline lane
  typedef struct packed {
    logic signed [31:0] grid_min;
    logic [30:0]        spacing;
    logic [30:0]        recip;
  } cfg_t;

  // One spline request entering a lane
  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic signed [CTR_W-1:0] center;
    logic signed [31:0]      position;
  } spl_req_t;

  // One spline result leaving a lane
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic signed [31:0] value;
  } spl_res_t;

endpackage

FILE: design/cbb_spline.sv
// ----------------------------------------------------------------------------
// cbb_spline: seven-stage pipeline evaluating one centered cubic B-spline
// Value or first derivative at a position for a spline centered on one node.
// ----------------------------------------------------------------------------
module cbb_spline (
  input  logic              clk,
  input  logic              rst_n,
  input  cbb_pkg::cfg_t     cfg,
  input  cbb_pkg::spl_req_t req,
  output cbb_pkg::spl_res_t res
);

  // Stage 1: node position offset center * spacing
  logic               s1_valid_r;
  logic               s1_kind_r;
  logic signed [31:0] s1_pos_r;
  logic signed [42:0] s1_cprod_r, s1_cprod_nxt;

  // Stage 2: offset magnitude, far and sign flags
  logic               s2_valid_r;
  logic               s2_kind_r;
  logic signed [44:0] diff;
  logic [43:0]        mag_a;
  logic [32:0]        s2_a_r, s2_a_nxt;
  logic               s2_far_r, s2_far_nxt;
  logic               s2_neg_r, s2_neg_nxt;

  // Stage 3: scaled offset z
  logic               s3_valid_r;
  logic               s3_kind_r;
  logic               s3_neg_r;
  logic [63:0]        s3_prod;
  logic               s3_zero_r, s3_zero_nxt;
  logic [16:0]        s3_z_r, s3_z_nxt;

  // Stage 4: t, u and their squares
  logic               s4_valid_r;
  logic               s4_kind_r;
  logic               s4_neg_r;
  logic               s4_zero_r;
  logic [17:0]        s4_t_r, s4_t_nxt;
  logic [16:0]        s4_u_r, s4_u_nxt;
  logic [34:0]        s4_t2_r, s4_t2_nxt;
  logic [32:0]        s4_u2_r, s4_u2_nxt;

  // Stage 5: cubes and derivative numerator
  logic               s5_valid_r;
  logic               s5_kind_r;
  logic               s5_neg_r;
  logic               s5_zero_r;
  logic [51:0]        s5_t3_r, s5_t3_nxt;
  logic [48:0]        s5_u3_r, s5_u3_nxt;
  logic [32:0]        s5_d_r, s5_d_nxt;

  // Stage 6: value quotient seed, derivative product
  logic               s6_valid_r;
  logic               s6_kind_r;
  logic               s6_neg_r;
  logic               s6_zero_r;
  logic [51:0]        num;
  logic [20:0]        s6_q_r, s6_q_nxt;
  logic [63:0]        s6_dp_r, s6_dp_nxt;

  // Stage 7: divide by 3, round, select
  logic [39:0]        vq;
  logic [64:0]        dsum;
  logic [31:0]        dmag;
  cbb_pkg::spl_res_t  res_r, res_nxt;

  always_comb begin
    s1_cprod_nxt = 43'(req.center) * 43'($signed({1'b0, cfg.spacing}));
  end

  always_comb begin
    diff       = 45'(s1_pos_r) - 45'(cfg.grid_min) - 45'(s1_cprod_r);
    mag_a      = diff[44] ? 44'(-diff) : 44'(diff);
    s2_a_nxt   = mag_a[32:0];
    s2_far_nxt = |mag_a[43:33];
    s2_neg_nxt = !diff[44] && (diff != '0);
  end

  always_comb begin
    s3_prod     = 64'(s2_a_r) * 64'(cfg.recip);
    // zero recip means z = 0 everywhere, so far offsets only count otherwise
    s3_zero_nxt = (s2_far_r && (cfg.recip != '0)) || (s3_prod[63:33] != '0);
    s3_z_nxt    = s3_prod[32:16];
  end

  always_comb begin
    s4_t_nxt  = cbb_pkg::Q_TWO - 18'(s3_z_r);
    s4_u_nxt  = (s4_t_nxt > cbb_pkg::Q_ONE) ? 17'(s4_t_nxt - cbb_pkg::Q_ONE) : '0;
    s4_t2_nxt = 35'(s4_t_nxt) * 35'(s4_t_nxt);
    s4_u2_nxt = 33'(s4_u_nxt) * 33'(s4_u_nxt);
  end

  always_comb begin
    s5_t3_nxt = 52'(s4_t2_r) * 52'(s4_t_r);
    s5_u3_nxt = 49'(s4_u2_r) * 49'(s4_u_r);
    // t^2 - 4u^2 stays below 2^33 over the whole support
    s5_d_nxt  = 33'(s4_t2_r - {s4_u2_r, 2'b00});
  end

  always_comb begin
    num       = s5_t3_r - {1'b0, s5_u3_r, 2'b00};
    s6_q_nxt  = 21'(num[51:32]) + cbb_pkg::VAL_RND;
    s6_dp_nxt = 64'(s5_d_r) * 64'(cfg.recip);
  end

  always_comb begin
    // q / 6 = (q >> 1) / 3
    vq            = 40'(s6_q_r[20:1]) * 40'(cbb_pkg::RECIP3_MUL);
    dsum          = 65'(s6_dp_r) + cbb_pkg::DER_RND;
    dmag          = dsum[64:33];
    res_nxt.valid = s6_valid_r;
    res_nxt.kind  = s6_kind_r;
    if (s6_zero_r) begin
      res_nxt.value = '0;
    end else if (!s6_kind_r) begin
      res_nxt.value = $signed(32'(vq[39:21]));
    end else if (s6_neg_r) begin
      res_nxt.value = -$signed(dmag);
    end else begin
      res_nxt.value = $signed(dmag);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      s1_valid_r  <= req.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      res_r.valid <= res_nxt.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    s1_kind_r   <= req.kind;
    s1_pos_r    <= req.position;
    s1_cprod_r  <= s1_cprod_nxt;

    s2_kind_r   <= s1_kind_r;
    s2_a_r      <= s2_a_nxt;
    s2_far_r    <= s2_far_nxt;
    s2_neg_r    <= s2_neg_nxt;

    s3_kind_r   <= s2_kind_r;
    s3_neg_r    <= s2_neg_r;
    s3_zero_r   <= s3_zero_nxt;
    s3_z_r      <= s3_z_nxt;

    s4_kind_r   <= s3_kind_r;
    s4_neg_r    <= s3_neg_r;
    s4_zero_r   <= s3_zero_r;
    s4_t_r      <= s4_t_nxt;
    s4_u_r      <= s4_u_nxt;
    s4_t2_r     <= s4_t2_nxt;
    s4_u2_r     <= s4_u2_nxt;

    s5_kind_r   <= s4_kind_r;
    s5_neg_r    <= s4_neg_r;
    s5_zero_r   <= s4_zero_r;
    s5_t3_r     <= s5_t3_nxt;
    s5_u3_r     <= s5_u3_nxt;
    s5_d_r      <= s5_d_nxt;

    s6_kind_r   <= s5_kind_r;
    s6_neg_r    <= s5_neg_r;
    s6_zero_r   <= s5_zero_r;
    s6_q_r      <= s6_q_nxt;
    s6_dp_r     <= s6_dp_nxt;

    res_r.kind  <= res_nxt.kind;
    res_r.value <= res_nxt.value;
  end

  assign res = res_r;

  // Basis values lie in [0, 2/3]
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.kind) |-> (!res.value[31] && (res.value <= cbb_pkg::VALUE_MAX)))
    else $error("basis value out of range");

  // An offset flagged outside the support at stage 3 gives a zero result
  a_zero_support: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_zero_r) |-> ##4 (res.valid && (res.value == '0)))
    else $error("spline outside support not zero");

endmodule

FILE: design/cbb_combine.sv
// ----------------------------------------------------------------------------
// cbb_combine: boundary correction sum and saturation
// Adds weight * neighbour spline to the main spline and clips to 32 bits.
// ----------------------------------------------------------------------------
module cbb_combine (
  input  logic               clk,
  input  logic               rst_n,
  input  cbb_pkg::spl_res_t  main_res,
  input  cbb_pkg::spl_res_t  nb_res,
  input  logic signed [3:0]  weight,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_sat
);

  logic signed [35:0] corr;
  logic signed [36:0] total;
  logic               valid_r;
  logic signed [31:0] value_r, value_nxt;
  logic               sat_r, sat_nxt;

  always_comb begin
    corr  = 36'(weight) * 36'(nb_res.value);
    total = 37'(main_res.value) + 37'(corr);
    if (total > 37'(cbb_pkg::SAT_HI)) begin
      value_nxt = cbb_pkg::SAT_HI;
      sat_nxt   = 1'b1;
    end else if (total < 37'(cbb_pkg::SAT_LO)) begin
      value_nxt = cbb_pkg::SAT_LO;
      sat_nxt   = 1'b1;
    end else begin
      value_nxt = 32'(total);
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= main_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_sat   = sat_r;

endmodule

FILE: design/cubic_bspline_basis_eval.sv
// ----------------------------------------------------------------------------
// cubic_bspline_basis_eval: cubic B-spline basis evaluator, Q16.16
// Basis value or first derivative of one grid node at a position, with a
// weighted neighbour-spline correction at the first and last node pairs.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                         Handshake
// -------   -------------------------------------------   ----------------------
// input     in_kind in_node_index in_position in_bc_code   start high, busy low
// result    out_basis_value out_saturated                  out_valid, one cycle
// config    cfg_index cfg_data                              cfg_we, no wait
//
// One item per clock. Every item runs through a fixed nine-register pipeline:
// input stage, seven spline stages (two lanes side by side, main node and
// boundary neighbour), then the combine/saturate stage, whose register
// drives out_valid. The stage depth is set by the 33 x 31 bit multiplies
// in the spline lanes.
// Reset (rst_n low, synchronous) clears all valid bits, loads register
// defaults and holds busy high; busy drops the cycle after reset ends.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module cubic_bspline_basis_eval (
  input  logic               clk,
  input  logic               rst_n,

  // input item
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [9:0]         in_node_index,
  input  logic signed [31:0] in_position,
  input  logic signed [4:0]  in_bc_code,

  // result item
  output logic               out_valid,
  output logic signed [31:0] out_basis_value,
  output logic               out_saturated,

  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned NODE_W = cbb_pkg::NODE_W;
  localparam int unsigned CTR_W  = cbb_pkg::CTR_W;
  localparam int unsigned LAT    = cbb_pkg::SPL_LAT;

  // Configuration registers
  logic signed [31:0] grid_min_r, grid_min_nxt;
  logic [30:0]        spacing_r, spacing_nxt;
  logic [30:0]        recip_r, recip_nxt;
  logic [9:0]         last_node_r, last_node_nxt;
  cbb_pkg::cfg_t      cfg;

  logic               busy_r;
  logic               acc;

  // Input stage decode
  logic [NODE_W-1:0]       node_m;
  logic [NODE_W-1:0]       lastn;
  logic [CTR_W-1:0]        lastn_m1;
  logic                    is_first;
  logic                    is_last_m1;
  logic                    is_last;
  logic                    code_ok;
  logic [3:0]              bc_row;
  logic [1:0]              bc_col;

  logic                    s0_valid_r;
  logic                    s0_kind_r;
  logic signed [31:0]      s0_pos_r;
  logic signed [CTR_W-1:0] s0_ctr_main_r, s0_ctr_main_nxt;
  logic signed [CTR_W-1:0] s0_ctr_nb_r, s0_ctr_nb_nxt;
  logic signed [3:0]       s0_weight_r, s0_weight_nxt;

  // Weight travels beside the spline lanes
  logic signed [3:0]       wt_pipe_r [LAT];

  cbb_pkg::spl_req_t       main_req, nb_req;
  cbb_pkg::spl_res_t       main_res, nb_res;

  // --------------------------------------------------------------------------
  // Configuration writes; upper data bits beyond a register are dropped
  // --------------------------------------------------------------------------
  always_comb begin
    grid_min_nxt  = grid_min_r;
    spacing_nxt   = spacing_r;
    recip_nxt     = recip_r;
    last_node_nxt = last_node_r;
    if (cfg_we) begin
      unique case (cbb_pkg::cfg_reg_t'(cfg_index))
        cbb_pkg::REG_GRID_MIN:  grid_min_nxt  = $signed(cfg_data);
        cbb_pkg::REG_SPACING:   spacing_nxt   = cfg_data[30:0];
        cbb_pkg::REG_RECIP:     recip_nxt     = cfg_data[30:0];
        cbb_pkg::REG_LAST_NODE: last_node_nxt = cfg_data[9:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_min_r  <= '0;
      spacing_r   <= 31'h0001_0000;
      recip_r     <= 31'h0001_0000;
      last_node_r <= 10'd1023;
      busy_r      <= 1'b1;
    end else begin
      grid_min_r  <= grid_min_nxt;
      spacing_r   <= spacing_nxt;
      recip_r     <= recip_nxt;
      last_node_r <= last_node_nxt;
      busy_r      <= 1'b0;
    end
  end

  assign cfg.grid_min = grid_min_r;
  assign cfg.spacing  = spacing_r;
  assign cfg.recip    = recip_r;

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  // --------------------------------------------------------------------------
  // Input stage: boundary place, neighbour center and weight lookup
  // --------------------------------------------------------------------------
  always_comb begin
    node_m     = in_node_index[NODE_W-1:0];
    lastn      = last_node_r[NODE_W-1:0];
    lastn_m1   = CTR_W'(lastn) - CTR_W'(1);
    // first pair wins over last pair when last_node is small
    is_first   = (node_m == '0) || (node_m == NODE_W'(1));
    is_last_m1 = (CTR_W'(node_m) == lastn_m1);
    is_last    = (node_m == lastn);
    code_ok    = !in_bc_code[4] && (in_bc_code[3:0] <= cbb_pkg::BC_ROW_MAX);
    bc_row     = in_bc_code[3:0];

    if (is_first) begin
      bc_col = node_m[1:0];
    end else if (is_last) begin
      bc_col = cbb_pkg::COL_LAST;
    end else begin
      bc_col = cbb_pkg::COL_LAST_M1;
    end

    if (code_ok && (is_first || is_last_m1 || is_last)) begin
      s0_weight_nxt = cbb_pkg::BC_WEIGHT[bc_row][bc_col];
    end else begin
      s0_weight_nxt = '0;
    end

    s0_ctr_main_nxt = $signed(CTR_W'(node_m));
    // last neighbour sits at last_node + 1, up to MAX_NODES
    if (is_first) begin
      s0_ctr_nb_nxt = -$signed(CTR_W'(1));
    end else begin
      s0_ctr_nb_nxt = $signed(CTR_W'(lastn) + CTR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s0_kind_r     <= in_kind;
    s0_pos_r      <= in_position;
    s0_ctr_main_r <= s0_ctr_main_nxt;
    s0_ctr_nb_r   <= s0_ctr_nb_nxt;
    s0_weight_r   <= s0_weight_nxt;
  end

  always_ff @(posedge clk) begin
    wt_pipe_r[0] <= s0_weight_r;
    for (int i = 1; i < LAT; i++) begin
      wt_pipe_r[i] <= wt_pipe_r[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Spline lanes: main node and boundary neighbour
  // --------------------------------------------------------------------------
  assign main_req.valid    = s0_valid_r;
  assign main_req.kind     = s0_kind_r;
  assign main_req.center   = s0_ctr_main_r;
  assign main_req.position = s0_pos_r;

  assign nb_req.valid    = s0_valid_r;
  assign nb_req.kind     = s0_kind_r;
  assign nb_req.center   = s0_ctr_nb_r;
  assign nb_req.position = s0_pos_r;

  cbb_spline u_spl_main (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (main_req),
    .res   (main_res)
  );

  cbb_spline u_spl_nb (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (nb_req),
    .res   (nb_res)
  );

  // --------------------------------------------------------------------------
  // Correction sum, saturation and result register
  // --------------------------------------------------------------------------
  cbb_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .main_res  (main_res),
    .nb_res    (nb_res),
    .weight    (wt_pipe_r[LAT-1]),
    .out_valid (out_valid),
    .out_value (out_basis_value),
    .out_sat   (out_saturated)
  );

  // No boundary correction for codes outside the table
  a_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_bc_code[4] || (in_bc_code[3:0] > cbb_pkg::BC_ROW_MAX)))
      |=> (s0_weight_r == '0))
    else $error("weight set for out-of-table boundary code");

  // Both lanes carry the same item
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (main_res.valid == nb_res.valid) && (!main_res.valid || (main_res.kind == nb_res.kind)))
    else $error("spline lanes out of step");

  // A clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated)
      |-> ((out_basis_value == cbb_pkg::SAT_HI) || (out_basis_value == cbb_pkg::SAT_LO)))
    else $error("saturated result not at a rail");

endmodule
